// File: rtl/cscan_pkg.sv
// Shared types and constants for the C-SCAN disk scheduler.
`default_nettype none
package cscan_pkg;

   localparam int MAX_REQ  = 32;
   localparam int TRACK_W  = 8;
   localparam int SEEK_W   = 10;
   localparam int SUM_W    = SEEK_W + 1;
   localparam int CNT_W    = $clog2(MAX_REQ + 1);
   localparam int IDX_W    = $clog2(MAX_REQ);
   localparam int SIZE_W   = 9;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_START_HEAD  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_COUNT = 1'b1;

   localparam logic [SIZE_W-1:0] TRACK_COUNT_RESET = 9'd200;
   localparam logic [SIZE_W-1:0] TRACK_COUNT_MAX   = 9'd256;
   localparam logic [SUM_W-1:0]  SEEK_SAT          = 11'd1023;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_UP,
      ST_ZERO,
      ST_DOWN
   } state_type;

   // Broadcast control for every cell of the sort chain.
   typedef struct packed {
      logic               load;
      logic               shift;
      logic               clear;
      logic [TRACK_W-1:0] new_track;
   } cell_ctl_type;

   // What a cell shows its right-hand neighbor.
   typedef struct packed {
      logic               occ;
      logic               gt;
      logic [TRACK_W-1:0] track;
   } cell_link_type;

endpackage
`default_nettype wire

// File: rtl/cscan_cell.sv
// One cell of the insertion-sort chain: holds one track, shifts on insert or rotate.
`default_nettype none
module cscan_cell (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  cscan_pkg::cell_ctl_type  ctl,
   input  wire  cscan_pkg::cell_link_type left,
   input  wire  [cscan_pkg::TRACK_W-1:0]  right_track,
   output cscan_pkg::cell_link_type       self_link
);
   import cscan_pkg::*;

   logic [TRACK_W-1:0] track_ff, track_in;
   logic               occ_ff, occ_in;
   logic               gt_self;

   assign gt_self = occ_ff && (track_ff > ctl.new_track);

   always_comb begin
      track_in = track_ff;
      occ_in   = occ_ff;
      if (ctl.clear) begin
         occ_in = 1'b0;
      end else if (ctl.load) begin
         // every held value above the new one moves one cell right
         if (left.gt) begin
            track_in = left.track;
            occ_in   = 1'b1;
         end else if (gt_self || (!occ_ff && left.occ)) begin
            track_in = ctl.new_track;
            occ_in   = 1'b1;
         end
      end else if (ctl.shift) begin
         track_in = right_track;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      track_ff <= track_in;
   end

   assign self_link.occ   = occ_ff;
   assign self_link.gt    = gt_self;
   assign self_link.track = track_ff;

endmodule
`default_nettype wire

// File: rtl/cscan_chain.sv
// Row of sort cells; loads sorted, rotates left within the held count.
`default_nettype none
module cscan_chain (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  cscan_pkg::cell_ctl_type ctl,
   input  wire  [cscan_pkg::IDX_W-1:0]   wrap_idx,
   output logic [cscan_pkg::TRACK_W-1:0] first_track
);
   import cscan_pkg::*;

   cell_link_type links [MAX_REQ];

   for (genvar i = 0; i < MAX_REQ; i++) begin : g_cell
      cell_link_type      left_link;
      logic [TRACK_W-1:0] right_track;

      if (i == 0) begin : g_first
         assign left_link = '{occ: 1'b1, gt: 1'b0, track: '0};
      end else begin : g_mid
         assign left_link = links[i-1];
      end

      // last held entry takes the front one, so the batch rotates in place
      if (i == MAX_REQ - 1) begin : g_tail
         assign right_track = links[0].track;
      end else begin : g_body
         assign right_track = (wrap_idx == IDX_W'(i)) ? links[0].track : links[i+1].track;
      end

      cscan_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left        (left_link),
         .right_track (right_track),
         .self_link   (links[i])
      );
   end

   assign first_track = links[0].track;

endmodule
`default_nettype wire

// File: rtl/cscan_disk_scheduler_unit.sv
// Top level of the C-SCAN disk scheduler: sequencer, seek sum and output register.
//
//  channel | ports                           | payload
//  --------+---------------------------------+----------------------------------------
//  req     | req_tvalid/tready/tdata/tlast   | tdata[7:0] request_track, tlast is_last
//  rsp     | rsp_tvalid/tready/tdata/tlast   | tdata[7:0] track, [17:8] total_seek
//  csr     | csr_we/csr_index/csr_wdata      | 0 start_head, 1 track count
//
// Requests load one per cycle in the load state into a 32-cell insertion-sort chain.
// After the last request the held ones rotate past the front, those above the head being
// emitted with the end track in order; then a turnaround, track 0 and each lower request.
// Output stalls hold each emitting step; rotations past unserved entries carry on.
// Requests are refused during emission; a held final result does not block them.
// Reset clears control and cell occupancy; there is no clearing pass.
`default_nettype none
module cscan_disk_scheduler_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] request_track
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] track, [17:8] total_seek, [23:18] zero
   output logic        rsp_tlast,
   input  wire         csr_we,
   input  wire  [cscan_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [cscan_pkg::SIZE_W-1:0]    csr_wdata
);
   import cscan_pkg::*;

   state_type          state_ff, state_in;
   logic [TRACK_W-1:0] head_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   down_ff, down_in;
   logic               end_done_ff, end_done_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TRACK_W-1:0] cur_ff, cur_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TRACK_W-1:0] rsp_track_ff, rsp_track_in;
   logic [SEEK_W-1:0]  rsp_seek_ff, rsp_seek_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_ctl_type       ctl;
   logic [TRACK_W-1:0] front;
   logic [TRACK_W-1:0] end_track;
   logic               out_free, in_acc;
   logic               up_more, front_gt, end_before;
   logic               up_emit_end, up_emit_req, up_skip, up_done;
   logic               emit, emit_last;
   logic [TRACK_W-1:0] emit_track;
   logic [TRACK_W-1:0] diff;
   logic [SUM_W-1:0]   sum_next;

   cscan_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .wrap_idx    (IDX_W'(count_ff - CNT_W'(1))),
      .first_track (front)
   );

   // track count saturates to 1..256
   always_comb begin
      if (size_ff == '0) begin
         end_track = '0;
      end else if (size_ff > TRACK_COUNT_MAX) begin
         end_track = '1;
      end else begin
         end_track = TRACK_W'(size_ff - SIZE_W'(1));
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign in_acc      = req_tvalid && req_tready;
   assign up_more     = idx_ff != count_ff;
   assign front_gt    = front > head_ff;
   assign end_before  = !end_done_ff && (end_track <= front);
   assign up_emit_end = (!up_more && !end_done_ff) || (up_more && front_gt && end_before);
   assign up_emit_req = up_more && front_gt && !end_before;
   assign up_skip     = up_more && !front_gt;
   assign up_done     = !up_more && end_done_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (in_acc && req_tlast) state_in = ST_UP;
         end
         ST_UP: begin
            if (up_done) state_in = ST_ZERO;
         end
         ST_ZERO: begin
            if (out_free) state_in = (down_ff == '0) ? ST_LOAD : ST_DOWN;
         end
         ST_DOWN: begin
            if (out_free && (idx_ff == down_ff - CNT_W'(1))) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // sequencer outputs and datapath
   always_comb begin
      ctl           = '{load: 1'b0, shift: 1'b0, clear: 1'b0, new_track: req_tdata};
      count_in      = count_ff;
      idx_in        = idx_ff;
      down_in       = down_ff;
      end_done_in   = end_done_ff;
      sum_in        = sum_ff;
      cur_in        = cur_ff;
      emit          = 1'b0;
      emit_last     = 1'b0;
      emit_track    = front;
      case (state_ff)
         ST_LOAD: begin
            if (in_acc) begin
               if (count_ff < CNT_W'(MAX_REQ)) begin
                  ctl.load = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  idx_in      = '0;
                  down_in     = '0;
                  end_done_in = 1'b0;
                  sum_in      = '0;
                  cur_in      = head_ff;
               end
            end
         end
         ST_UP: begin
            if (up_skip) begin
               // at or below head: rotate past; lower ones come back in the down pass
               ctl.shift = 1'b1;
               idx_in    = idx_ff + CNT_W'(1);
               if (front < head_ff) down_in = down_ff + CNT_W'(1);
            end else if (up_emit_end && out_free) begin
               emit        = 1'b1;
               emit_track  = end_track;
               end_done_in = 1'b1;
            end else if (up_emit_req && out_free) begin
               emit      = 1'b1;
               ctl.shift = 1'b1;
               idx_in    = idx_ff + CNT_W'(1);
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_track = '0;
               emit_last  = down_ff == '0;
               idx_in     = '0;
               if (down_ff == '0) begin
                  ctl.clear = 1'b1;
                  count_in  = '0;
               end
            end
         end
         ST_DOWN: begin
            if (out_free) begin
               emit      = 1'b1;
               ctl.shift = 1'b1;
               idx_in    = idx_ff + CNT_W'(1);
               emit_last = idx_ff == down_ff - CNT_W'(1);
               if (emit_last) begin
                  ctl.clear = 1'b1;
                  count_in  = '0;
               end
            end
         end
         default: begin
            ctl.clear = 1'b1;
            count_in  = '0;
         end
      endcase

      diff = (emit_track > cur_ff) ? emit_track - cur_ff : cur_ff - emit_track;
      // the return sweep counts as the end track's distance
      if (state_ff == ST_ZERO) begin
         sum_next = sum_ff + SUM_W'(end_track);
      end else begin
         sum_next = sum_ff + SUM_W'(diff);
      end

      if (emit) begin
         sum_in = sum_next;
         cur_in = emit_track;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_track_in = rsp_track_ff;
      rsp_seek_in  = rsp_seek_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_track_in = emit_track;
         rsp_last_in  = emit_last;
         if (!emit_last) begin
            rsp_seek_in = '0;
         end else if (sum_next > SEEK_SAT) begin
            rsp_seek_in = '1;
         end else begin
            rsp_seek_in = SEEK_W'(sum_next);
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         head_ff      <= '0;
         size_ff      <= TRACK_COUNT_RESET;
         count_ff     <= '0;
         idx_ff       <= '0;
         down_ff      <= '0;
         end_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         down_ff      <= down_in;
         end_done_ff  <= end_done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_START_HEAD:  head_ff <= TRACK_W'(csr_wdata);
               CSR_TRACK_COUNT: size_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      sum_ff       <= sum_in;
      cur_ff       <= cur_in;
      rsp_track_ff <= rsp_track_in;
      rsp_seek_ff  <= rsp_seek_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = state_ff == ST_LOAD;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'b0, rsp_seek_ff, rsp_track_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REQ))
      else $error("request count above chain length");

   a_seek_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_seek_ff == '0))
      else $error("seek total on a non-final result");

   a_down_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOWN) |-> (idx_ff < down_ff))
      else $error("down pass index past lower count");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (state_ff == ST_UP))
      else $error("final request did not start emission");

endmodule
`default_nettype wire

// File: dv/cscan_disk_scheduler_unit_test.sv
// Self-checking testbench for the C-SCAN disk scheduler: predicts each service sequence.
`timescale 1ns / 1ps

module cscan_disk_scheduler_unit_test;
   import cscan_pkg::*;

   localparam int ITEM_TARGET   = 420;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 2000;

   typedef struct packed {
      logic [7:0] track;
      logic [9:0] seek;
      logic       last;
   } visit_type;

   // Keeps the batch being collected and the visits the block still owes.
   class cscan_service_board;
      logic [7:0] head_reg;
      logic [8:0] size_reg;
      logic [7:0] held[MAX_REQ];
      int         held_count;
      int         tally[2][256];   // [0] upward sweep, [1] downward sweep
      int         route[MAX_REQ + 2];
      int         route_len;
      int         route_sum;
      int         route_pos;
      visit_type  expected_visits[$];
      int         faults;
      int         visits_seen;
      int         batches_done;

      function void reset_state();
         head_reg = '0;
         size_reg = TRACK_COUNT_RESET;
         held_count = 0;
         faults = 0;
         visits_seen = 0;
         batches_done = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
         if (idx == CSR_START_HEAD)
            head_reg = value[7:0];
         else if (idx == CSR_TRACK_COUNT)
            size_reg = value;
      endfunction

      function void serve_pass(int side);
         for (int t = 0; t < 256; t++) begin
            for (int c = 0; c < tally[side][t]; c++) begin
               route_sum += (t > route_pos) ? t - route_pos : route_pos - t;
               route_pos = t;
               route[route_len] = t;
               route_len++;
            end
         end
      endfunction

      function void note_request(logic [7:0] t, logic last);
         int eff;
         visit_type vis;
         if (held_count < MAX_REQ) begin
            held[held_count] = t;
            held_count++;
         end
         if (!last)
            return;
         eff = int'(size_reg);
         if (eff < 1)
            eff = 1;
         if (eff > 256)
            eff = 256;
         for (int i = 0; i < 256; i++) begin
            tally[0][i] = 0;
            tally[1][i] = 0;
         end
         tally[0][eff - 1]++;
         tally[1][0]++;
         for (int i = 0; i < held_count; i++) begin
            if (held[i] > head_reg)
               tally[0][held[i]]++;
            else if (held[i] < head_reg)
               tally[1][held[i]]++;
         end
         route_len = 0;
         route_sum = 0;
         route_pos = int'(head_reg);
         serve_pass(0);
         // return sweep is charged as the full disk
         route_sum += eff - 1;
         route_pos = 0;
         serve_pass(1);
         if (route_sum > 1023)
            route_sum = 1023;
         for (int i = 0; i < route_len; i++) begin
            vis.track = 8'(route[i]);
            vis.seek  = (i == route_len - 1) ? 10'(route_sum) : 10'd0;
            vis.last  = (i == route_len - 1);
            expected_visits = {expected_visits, vis};
         end
         held_count = 0;
         batches_done++;
      endfunction

      function void check_visit(visit_type got);
         visit_type want;
         visits_seen++;
         if (expected_visits.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result: track %0d seek %0d last %0b",
                        got.track, got.seek, got.last);
            return;
         end
         want = expected_visits.pop_front();
         if (got.track !== want.track || got.seek !== want.seek || got.last !== want.last) begin
            faults++;
            if (faults <= 10)
               $display({"mismatch: expected track %0d seek %0d last %0b, ",
                         "got track %0d seek %0d last %0b"},
                        want.track, want.seek, want.last, got.track, got.seek, got.last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;

   cscan_service_board sb;
   int  items_sent;
   int  settings_done;
   bit  req_gaps_on;
   int  rsp_stall_pct;
   int  hold_requests;
   int  idle_cycles;

   cscan_disk_scheduler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_track(input logic [7:0] h);
      logic [7:0] t;
      case ($urandom_range(0, 9))
         0: t = h;
         1: t = 8'd0;
         2: t = 8'd255;
         3: t = h + 8'($urandom_range(0, 4)) - 8'd2;
         default: t = 8'($urandom_range(0, 255));
      endcase
      return t;
   endfunction

   function automatic int pick_batch_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(1, 6);
      else if (r < 85)
         return $urandom_range(7, 20);
      else if (r < 95)
         return $urandom_range(21, 32);
      return $urandom_range(33, 40);
   endfunction

   task automatic send_request(input logic [7:0] t, input logic last);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(t, last);
      items_sent++;
   endtask

   task automatic send_batch(input int len, input logic [7:0] h);
      for (int i = 0; i < len; i++)
         send_request(pick_track(h), i == len - 1);
   endtask

   task automatic set_regs(input logic [7:0] h, input logic [SIZE_W-1:0] s);
      csr_we    <= 1'b1;
      csr_index <= CSR_START_HEAD;
      csr_wdata <= {1'b0, h};
      @(posedge clock);
      sb.write_reg(CSR_START_HEAD, {1'b0, h});
      csr_index <= CSR_TRACK_COUNT;
      csr_wdata <= s;
      @(posedge clock);
      sb.write_reg(CSR_TRACK_COUNT, s);
      csr_we <= 1'b0;
      settings_done++;
   endtask

   // stop offering, wait out every owed visit plus the block's tail
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_visits.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: check, then choose next ready
   initial begin
      visit_type got;
      int stall_left;
      int holds_taken;
      stall_left = 0;
      holds_taken = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.track = rsp_tdata[7:0];
            got.seek  = rsp_tdata[17:8];
            got.last  = rsp_tlast;
            sb.check_visit(got);
         end
         if (hold_requests != holds_taken) begin
            holds_taken = hold_requests;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [7:0] h;
      logic [SIZE_W-1:0] s;
      int r;
      int nb;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      items_sent = 0;
      settings_done = 0;
      req_gaps_on = 1'b0;
      rsp_stall_pct = 0;
      hold_requests = 0;
      sb = new;
      sb.reset_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // head inside the disk: head match, duplicates, extremes, track past the end
      set_regs(8'd100, 9'd200);
      rsp_stall_pct = 30;
      send_request(8'd150, 1'b0);
      send_request(8'd100, 1'b0);
      send_request(8'd20, 1'b0);
      send_request(8'd255, 1'b0);
      send_request(8'd0, 1'b0);
      send_request(8'd199, 1'b0);
      send_request(8'd150, 1'b1);
      // batch made only of a head match
      send_request(8'd100, 1'b1);
      settle();

      set_regs(8'd0, 9'd256);
      req_gaps_on = 1'b1;
      send_request(8'd0, 1'b0);
      send_request(8'd255, 1'b0);
      send_request(8'd1, 1'b0);
      send_request(8'd0, 1'b1);
      settle();

      // end track below the head
      set_regs(8'd255, 9'd1);
      send_request(8'd255, 1'b0);
      send_request(8'd254, 1'b0);
      send_request(8'd0, 1'b1);
      settle();

      // disk size zero acts as one track
      set_regs(8'd128, 9'd0);
      send_request(8'd200, 1'b0);
      send_request(8'd50, 1'b1);
      settle();

      // disk size above the maximum saturates
      set_regs(8'd10, 9'd511);
      send_request(8'd5, 1'b0);
      send_request(8'd250, 1'b1);
      settle();

      set_regs(8'd200, 9'd100);
      send_request(8'd150, 1'b0);
      send_request(8'd210, 1'b0);
      send_request(8'd99, 1'b1);
      settle();

      // receiver holds off while batches keep coming; second one overflows the store
      set_regs(8'd128, 9'd256);
      req_gaps_on = 1'b0;
      rsp_stall_pct = 0;
      hold_requests++;
      send_batch(20, 8'd128);
      send_batch(36, 8'd128);
      settle();

      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 9);
         h = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
         r = $urandom_range(0, 99);
         if (r < 8)
            s = 9'd0;
         else if (r < 16)
            s = 9'($urandom_range(257, 511));
         else if (r < 26)
            s = 9'd256;
         else if (r < 32)
            s = 9'd1;
         else
            s = 9'($urandom_range(1, 256));
         set_regs(h, s);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0: rsp_stall_pct = 0;
            1: rsp_stall_pct = 10;
            2: rsp_stall_pct = 30;
            default: rsp_stall_pct = 60;
         endcase
         nb = $urandom_range(2, 5);
         for (int b = 0; b < nb && items_sent < ITEM_TARGET; b++)
            send_batch(pick_batch_len(), h);
         settle();
      end

      if (sb.expected_visits.size() != 0) begin
         sb.faults++;
         $display("%0d expected results never arrived", sb.expected_visits.size());
      end
      $display("Sent %0d requests in %0d batches over %0d register settings; checked %0d results.",
               items_sent, sb.batches_done, settings_done, sb.visits_seen);
      $display("Mismatches: %0d.", sb.faults);
      if (sb.faults == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/cscan_pkg.sv
rtl/cscan_cell.sv
rtl/cscan_chain.sv
rtl/cscan_disk_scheduler_unit.sv
dv/cscan_disk_scheduler_unit_test.sv
